@@ design/psdb_pkg.sv @@
// psdb_pkg: shared codes and types for the point splat depth buffer
// used by the divider and the top level; depends on nothing

package psdb_pkg;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_SPLAT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [2:0] CFG_FOCAL_X    = 3'd0;
	localparam logic [2:0] CFG_FOCAL_Y    = 3'd1;
	localparam logic [2:0] CFG_CENTER_X   = 3'd2;
	localparam logic [2:0] CFG_CENTER_Y   = 3'd3;
	localparam logic [2:0] CFG_NEAR_DEPTH = 3'd4;
	localparam logic [2:0] CFG_FAR_DEPTH  = 3'd5;
	localparam logic [2:0] CFG_SPLAT_RAD  = 3'd6;
	localparam logic [2:0] CFG_FRUSTUM_EN = 3'd7;

	localparam logic [31:0] EMPTY_DEPTH = 32'hFFFF_FFFF;
	localparam logic [31:0] BYTE_SCALE2 = 32'd510;
	localparam logic [7:0]  BYTE_MAX    = 8'd255;

	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
		logic [63:0] divisor;
	} div_req_t;

endpackage

@@ design/psdb_req_if.sv @@
// psdb_req_if: input item channel of the point splat depth buffer
// valid/ready handshake with opcode, point and pixel address payload

interface psdb_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         opcode;
	logic signed [31:0] cam_x;
	logic signed [31:0] cam_y;
	logic signed [31:0] cam_z;
	logic [18:0]        pixel_address;

	modport source(output valid, opcode, cam_x, cam_y, cam_z, pixel_address, input ready);
	modport sink(input valid, opcode, cam_x, cam_y, cam_z, pixel_address, output ready);
endinterface

@@ design/psdb_rsp_if.sv @@
// psdb_rsp_if: result channel of the point splat depth buffer
// valid/ready handshake with depth, depth byte and address payload

interface psdb_rsp_if;
	logic        valid;
	logic        ready;
	logic [31:0] depth_value;
	logic [7:0]  depth_byte;
	logic [18:0] read_address;

	modport source(output valid, depth_value, depth_byte, read_address, input ready);
	modport sink(input valid, depth_value, depth_byte, read_address, output ready);
endinterface

@@ design/psdb_div.sv @@
// psdb_div: restoring divider, one quotient bit per cycle
// depends on psdb_pkg for the request struct

module psdb_div #(
	parameter int QW = 11
) (
	input  logic               clk,
	input  logic               arst_n,
	input  psdb_pkg::div_req_t req,
	output logic               done,
	output logic [QW-1:0]      quot
);

	localparam int CNW = $clog2(QW);

	logic [63:0]    rem_q;
	logic [63:0]    dsh_q;
	logic [QW-1:0]  quot_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic           ge;

	assign ge   = rem_q >= dsh_q;
	assign done = done_q;
	assign quot = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && (cnt_q == '0)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			dsh_q  <= req.divisor << (QW - 1);
			cnt_q  <= CNW'(QW - 1);
			quot_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q  <= dsh_q >> 1;
			quot_q <= {quot_q[QW-2:0], ge};
			cnt_q  <= cnt_q - 1'b1;
		end
	end

endmodule

@@ design/point_splat_depth_buffer_top.sv @@
// point_splat_depth_buffer_top: depth image with pinhole projection and square splats
// depends on psdb_pkg, psdb_req_if, psdb_rsp_if and psdb_div
//
// Items are taken one at a time. Reset and a clear item sweep the depth memory at one
// pixel per cycle over IMAGE_WIDTH*IMAGE_HEIGHT pixels (307200 at 640x480); no item is
// taken during the sweep. A point is projected on each axis by the shared serial
// divider, whose quotient has DQ bits (11 at 640x480), and the splat does one
// read-modify-write of the depth memory per pixel. A read reuses the divider for the
// depth byte. A finished result waits in an output register while the next item is
// taken.

module point_splat_depth_buffer_top #(
	parameter int IMAGE_WIDTH      = 640,
	parameter int IMAGE_HEIGHT     = 480,
	parameter int MAX_SPLAT_RADIUS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	psdb_req_if.sink    req,
	psdb_rsp_if.source  rsp,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int PIX    = IMAGE_WIDTH * IMAGE_HEIGHT;
	localparam int AW     = (PIX > 1) ? $clog2(PIX) : 1;
	localparam int MAXDIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
	localparam int CW     = $clog2(MAXDIM) + 1;
	localparam int DQ     = (CW > 8) ? CW : 8;
	localparam int RW     = $clog2(MAX_SPLAT_RADIUS + 2);
	localparam int EW     = ((CW > RW) ? CW : RW) + 1;
	localparam logic [31:0] X_EDGE  = 32'((IMAGE_WIDTH - 1) * 256);
	localparam logic [31:0] Y_EDGE  = 32'((IMAGE_HEIGHT - 1) * 256);
	localparam logic [31:0] X_SPAN2 = 32'(2 * IMAGE_WIDTH - 1);
	localparam logic [31:0] Y_SPAN2 = 32'(2 * IMAGE_HEIGHT - 1);

	typedef enum logic [14:0] {
		ST_CLR    = 15'h0001,
		ST_IDLE   = 15'h0002,
		ST_DCHK   = 15'h0004,
		ST_MUL    = 15'h0008,
		ST_ACHK   = 15'h0010,
		ST_DIVW   = 15'h0020,
		ST_SETUP  = 15'h0040,
		ST_SPLAT  = 15'h0080,
		ST_DRAIN  = 15'h0100,
		ST_RDMEM  = 15'h0200,
		ST_RDDAT  = 15'h0400,
		ST_RDMUL  = 15'h0800,
		ST_RDCHK  = 15'h1000,
		ST_RDDIV  = 15'h2000,
		ST_RESULT = 15'h4000
	} state_t;

	state_t state_q;

	// configuration
	logic [23:0] fx_q, fy_q, cx_q, cy_q;
	logic [31:0] near_q, far_q;
	logic [2:0]  rad_q;
	logic        fen_q;

	// item payload
	logic signed [31:0] x_q, y_q, z_q;
	logic [18:0]        addr_q;

	// projection
	logic          axis_q;
	logic [1:0]    step_q;
	logic [63:0]   fa_q, mz_q, cz_q, bz_q;
	logic [CW-1:0] u0_q, v0_q;

	// splat walk
	logic [CW-1:0] u_q, v_q, ulo_q, uhi_q, vhi_q;
	logic [AW-1:0] rowbase_q;
	logic [AW-1:0] addr_s1;
	logic          vld_s1;
	logic [AW-1:0] clr_q;

	// read path
	logic        hit_q;
	logic [31:0] d_q;
	logic [63:0] p510_q;
	logic [7:0]  byte_q;

	// output register
	logic        ov_q;
	logic [31:0] ov_depth_q;
	logic [7:0]  ov_byte_q;
	logic [18:0] ov_addr_q;

	// memory
	logic [31:0]   mem [PIX];
	logic [31:0]   mem_rd_q;
	logic          mem_re, mem_we;
	logic [AW-1:0] mem_raddr, mem_waddr;
	logic [31:0]   mem_wdata;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;

	// divider
	psdb_pkg::div_req_t div_req;
	logic               div_done;
	logic [DQ-1:0]      div_quot;

	// per-axis selection
	logic signed [31:0] a_sel;
	logic [31:0]        a_abs;
	logic [23:0]        f_sel, c_sel;
	logic [31:0]        edge_sel, span_sel, m_sel, zu;
	logic signed [63:0] sfa, num2, den, bnd;
	logic               ach_ok;

	// splat bounds
	logic [EW-1:0] r_e, u0_e, v0_e, ulo_e, uhi_e, vlo_e, vhi_e;

	// depth byte
	logic [63:0] rd_num;
	logic        rd_divide;

	logic accept;
	logic out_load;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_RESULT) && (!ov_q || rsp.ready);

	assign rsp.valid        = ov_q;
	assign rsp.depth_value  = ov_depth_q;
	assign rsp.depth_byte   = ov_byte_q;
	assign rsp.read_address = ov_addr_q;

	assign zu       = z_q;
	assign a_sel    = axis_q ? y_q : x_q;
	assign a_abs    = a_sel[31] ? (~a_sel + 32'd1) : a_sel;
	assign f_sel    = axis_q ? fy_q : fx_q;
	assign c_sel    = axis_q ? cy_q : cx_q;
	assign edge_sel = axis_q ? Y_EDGE : X_EDGE;
	assign span_sel = axis_q ? Y_SPAN2 : X_SPAN2;
	assign m_sel    = ({7'd0, c_sel, 1'b0} > edge_sel) ? {8'd0, c_sel} :
		(edge_sel - {8'd0, c_sel});

	always_comb begin
		mul_a = {8'd0, f_sel};
		mul_b = a_abs;
		if (state_q == ST_RDMUL) begin
			mul_a = d_q;
			mul_b = psdb_pkg::BYTE_SCALE2;
		end else begin
			unique case (step_q)
				2'd0: begin
					mul_a = {8'd0, f_sel};
					mul_b = a_abs;
				end
				2'd1: begin
					mul_a = m_sel;
					mul_b = zu;
				end
				2'd2: begin
					mul_a = {8'd0, c_sel};
					mul_b = zu;
				end
				default: begin
					mul_a = zu;
					mul_b = span_sel;
				end
			endcase
		end
	end

	assign mul_p = mul_a * mul_b;

	assign sfa    = a_sel[31] ? -$signed(fa_q) : $signed(fa_q);
	assign num2   = (sfa + $signed(cz_q)) <<< 1;
	assign den    = $signed({24'd0, zu, 8'd0});
	assign bnd    = $signed(bz_q << 8);
	assign ach_ok = (!fen_q || (fa_q <= mz_q)) && (num2 > -den) && (num2 < bnd);

	assign rd_num    = p510_q + {32'd0, far_q};
	assign rd_divide = (d_q != '0) && (far_q != '0) && (rd_num < ({32'd0, far_q} << 9));

	always_comb begin
		div_req.start    = ((state_q == ST_ACHK) && ach_ok) ||
			((state_q == ST_RDCHK) && rd_divide);
		div_req.dividend = (state_q == ST_ACHK) ? 64'(num2 + den) : rd_num;
		div_req.divisor  = (state_q == ST_ACHK) ? 64'(den <<< 1) : {31'd0, far_q, 1'b0};
	end

	psdb_div #(.QW(DQ)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_comb begin
		r_e   = ({29'd0, rad_q} > 32'(MAX_SPLAT_RADIUS)) ? EW'(MAX_SPLAT_RADIUS) : EW'(rad_q);
		u0_e  = EW'(u0_q);
		v0_e  = EW'(v0_q);
		ulo_e = (u0_e >= r_e) ? (u0_e - r_e) : '0;
		vlo_e = (v0_e >= r_e) ? (v0_e - r_e) : '0;
		uhi_e = ((u0_e + r_e) > EW'(IMAGE_WIDTH - 1)) ? EW'(IMAGE_WIDTH - 1) : (u0_e + r_e);
		vhi_e = ((v0_e + r_e) > EW'(IMAGE_HEIGHT - 1)) ? EW'(IMAGE_HEIGHT - 1) : (v0_e + r_e);
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rowbase_q + AW'(u_q);
		mem_we    = 1'b0;
		mem_waddr = addr_s1;
		mem_wdata = zu;
		if (state_q == ST_SPLAT) begin
			mem_re = 1'b1;
		end else if (state_q == ST_RDMEM) begin
			mem_re    = (32'(addr_q) < 32'(PIX));
			mem_raddr = AW'(32'(addr_q));
		end
		if (state_q == ST_CLR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = psdb_pkg::EMPTY_DEPTH;
		end else if (vld_s1 && (zu < mem_rd_q)) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rd_q <= mem[mem_raddr];
		end
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q   <= 24'd128000;
			fy_q   <= 24'd128000;
			cx_q   <= 24'd81920;
			cy_q   <= 24'd61440;
			near_q <= 32'd3277;
			far_q  <= 32'd655360;
			rad_q  <= 3'd1;
			fen_q  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				psdb_pkg::CFG_FOCAL_X:    fx_q   <= cfg_data[23:0];
				psdb_pkg::CFG_FOCAL_Y:    fy_q   <= cfg_data[23:0];
				psdb_pkg::CFG_CENTER_X:   cx_q   <= cfg_data[23:0];
				psdb_pkg::CFG_CENTER_Y:   cy_q   <= cfg_data[23:0];
				psdb_pkg::CFG_NEAR_DEPTH: near_q <= cfg_data;
				psdb_pkg::CFG_FAR_DEPTH:  far_q  <= cfg_data;
				psdb_pkg::CFG_SPLAT_RAD:  rad_q  <= cfg_data[2:0];
				default:                  fen_q  <= cfg_data[0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
			ov_q    <= 1'b0;
			axis_q  <= 1'b0;
			step_q  <= 2'd0;
		end else begin
			vld_s1 <= (state_q == ST_SPLAT);
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PIX - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						axis_q <= 1'b0;
						step_q <= 2'd0;
						clr_q  <= '0;
						unique case (req.opcode)
							psdb_pkg::OP_CLEAR: state_q <= ST_CLR;
							psdb_pkg::OP_SPLAT: state_q <= ST_DCHK;
							psdb_pkg::OP_READ:  state_q <= ST_RDMEM;
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DCHK: begin
					if (($signed({z_q[31], z_q}) > $signed({1'b0, near_q})) &&
						($signed({z_q[31], z_q}) <= $signed({1'b0, far_q}))) begin
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						state_q <= ST_ACHK;
					end
				end
				ST_ACHK: begin
					state_q <= ach_ok ? ST_DIVW : ST_IDLE;
				end
				ST_DIVW: begin
					if (div_done) begin
						if (!axis_q) begin
							axis_q  <= 1'b1;
							step_q  <= 2'd0;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					state_q <= ST_SPLAT;
				end
				ST_SPLAT: begin
					if ((u_q == uhi_q) && (v_q == vhi_q)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				ST_RDMEM: begin
					state_q <= ST_RDDAT;
				end
				ST_RDDAT: begin
					state_q <= ST_RDMUL;
				end
				ST_RDMUL: begin
					state_q <= ST_RDCHK;
				end
				ST_RDCHK: begin
					state_q <= rd_divide ? ST_RDDIV : ST_RESULT;
				end
				ST_RDDIV: begin
					if (div_done) begin
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= req.cam_x;
			y_q    <= req.cam_y;
			z_q    <= req.cam_z;
			addr_q <= req.pixel_address;
		end
		if (state_q == ST_MUL) begin
			unique case (step_q)
				2'd0:    fa_q <= mul_p;
				2'd1:    mz_q <= mul_p;
				2'd2:    cz_q <= mul_p;
				default: bz_q <= mul_p;
			endcase
		end
		if ((state_q == ST_DIVW) && div_done) begin
			if (!axis_q) begin
				u0_q <= div_quot[CW-1:0];
			end else begin
				v0_q <= div_quot[CW-1:0];
			end
		end
		if (state_q == ST_SETUP) begin
			u_q       <= CW'(ulo_e);
			v_q       <= CW'(vlo_e);
			ulo_q     <= CW'(ulo_e);
			uhi_q     <= CW'(uhi_e);
			vhi_q     <= CW'(vhi_e);
			rowbase_q <= AW'(32'(vlo_e) * 32'(IMAGE_WIDTH));
		end
		if (state_q == ST_SPLAT) begin
			addr_s1 <= mem_raddr;
			if (u_q == uhi_q) begin
				if (v_q != vhi_q) begin
					v_q       <= v_q + 1'b1;
					u_q       <= ulo_q;
					rowbase_q <= rowbase_q + AW'(IMAGE_WIDTH);
				end
			end else begin
				u_q <= u_q + 1'b1;
			end
		end
		if (state_q == ST_RDMEM) begin
			hit_q <= mem_re;
		end
		if (state_q == ST_RDDAT) begin
			d_q <= (hit_q && (mem_rd_q != psdb_pkg::EMPTY_DEPTH)) ? mem_rd_q : '0;
		end
		if (state_q == ST_RDMUL) begin
			p510_q <= mul_p;
		end
		if (state_q == ST_RDCHK) begin
			byte_q <= (d_q == '0) ? 8'd0 : psdb_pkg::BYTE_MAX;
		end
		if ((state_q == ST_RDDIV) && div_done) begin
			byte_q <= div_quot[7:0];
		end
		if (out_load) begin
			ov_depth_q <= d_q;
			ov_byte_q  <= byte_q;
			ov_addr_q  <= addr_q;
		end
	end

endmodule

@@ tb/sv/point_splat_depth_buffer_top_tb.sv @@
// point_splat_depth_buffer_top_tb: self-checking bench for the point splat depth buffer
// depends on psdb_pkg, psdb_req_if, psdb_rsp_if and the point_splat_depth_buffer_top RTL
// a depth image model predicts every pixel read under random traffic and several settings

module point_splat_depth_buffer_top_tb;

	localparam int IMG_W = 640;
	localparam int IMG_H = 480;
	localparam int PIXELS = IMG_W * IMG_H;
	localparam int RAD_MAX = 4;
	localparam logic [1:0] OP_IGNORED = 2'd3;
	localparam int IDLE_LIMIT = 1000000;
	localparam int SETTLE = 300;

	typedef struct {
		logic [31:0] depth_value;
		logic [7:0]  depth_byte;
		logic [18:0] read_address;
	} pixel_read_t;

	class depth_image_scoreboard;
		logic [31:0] depth_of[int];
		pixel_read_t pending_reads[$];
		logic [23:0] fx, fy, cx, cy;
		logic [31:0] near_z, far_z;
		logic [2:0] radius;
		logic frustum_on;
		int errors;
		int reads_checked;
		int points_written;

		function new();
			fx = 24'd128000;
			fy = 24'd128000;
			cx = 24'd81920;
			cy = 24'd61440;
			near_z = 32'd3277;
			far_z = 32'd655360;
			radius = 3'd1;
			frustum_on = 1'b1;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] val);
			case (idx)
				psdb_pkg::CFG_FOCAL_X: fx = val[23:0];
				psdb_pkg::CFG_FOCAL_Y: fy = val[23:0];
				psdb_pkg::CFG_CENTER_X: cx = val[23:0];
				psdb_pkg::CFG_CENTER_Y: cy = val[23:0];
				psdb_pkg::CFG_NEAR_DEPTH: near_z = val;
				psdb_pkg::CFG_FAR_DEPTH: far_z = val;
				psdb_pkg::CFG_SPLAT_RAD: radius = val[2:0];
				default: frustum_on = val[0];
			endcase
		endfunction

		function bit in_frustum(longint a, longint f, longint c, longint sz, longint z);
			longint other, m, mag;
			other = (sz - 1) * 256 - c;
			m = c > other ? c : other;
			mag = a < 0 ? -a : a;
			return mag * f <= m * z;
		endfunction

		function longint project(longint a, longint f, longint c, longint z);
			longint num, den;
			num = f * a + c * z;
			den = 256 * z;
			if (num >= 0)
				return (2 * num + den) / (2 * den);
			return -((-2 * num + den) / (2 * den));
		endfunction

		function logic [7:0] scale_byte(logic [31:0] d);
			longint unsigned q;
			if (d == 0)
				return 8'd0;
			if (far_z == 0)
				return psdb_pkg::BYTE_MAX;
			q = (longint'(d) * 510 + longint'(far_z)) / (2 * longint'(far_z));
			return q > 255 ? psdb_pkg::BYTE_MAX : q[7:0];
		endfunction

		function void splat(logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
			longint u0, v0, r, u, v, zl, ulo, uhi, vlo, vhi;
			int id;
			zl = z;
			if (zl <= longint'(near_z) || zl > longint'(far_z))
				return;
			if (frustum_on) begin
				if (!in_frustum(x, fx, cx, IMG_W, zl) || !in_frustum(y, fy, cy, IMG_H, zl))
					return;
			end
			u0 = project(x, fx, cx, zl);
			v0 = project(y, fy, cy, zl);
			if (u0 < 0 || u0 >= IMG_W || v0 < 0 || v0 >= IMG_H)
				return;
			points_written++;
			r = radius > RAD_MAX ? RAD_MAX : radius;
			ulo = u0 - r < 0 ? 0 : u0 - r;
			uhi = u0 + r > IMG_W - 1 ? IMG_W - 1 : u0 + r;
			vlo = v0 - r < 0 ? 0 : v0 - r;
			vhi = v0 + r > IMG_H - 1 ? IMG_H - 1 : v0 + r;
			for (v = vlo; v <= vhi; v++) begin
				for (u = ulo; u <= uhi; u++) begin
					id = int'(v * IMG_W + u);
					if (!depth_of.exists(id) || z < depth_of[id])
						depth_of[id] = z;
				end
			end
		endfunction

		function void note_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
				logic signed [31:0] z, logic [18:0] addr);
			pixel_read_t e;
			case (op)
				psdb_pkg::OP_CLEAR: depth_of.delete();
				psdb_pkg::OP_SPLAT: splat(x, y, z);
				psdb_pkg::OP_READ: begin
					e.depth_value = (addr < PIXELS && depth_of.exists(addr)) ?
						depth_of[addr] : 32'd0;
					e.depth_byte = scale_byte(e.depth_value);
					e.read_address = addr;
					pending_reads = {pending_reads, e};
				end
				default: ;
			endcase
		endfunction

		function void check_result(logic [31:0] dv, logic [7:0] db, logic [18:0] ra);
			pixel_read_t e;
			if (pending_reads.size() == 0) begin
				$error("unexpected result transfer: depth_value %0d address %0d", dv, ra);
				errors++;
				return;
			end
			e = pending_reads.pop_front();
			reads_checked++;
			if (dv !== e.depth_value) begin
				$error("depth_value: expected %0d actual %0d", e.depth_value, dv);
				errors++;
			end
			if (db !== e.depth_byte) begin
				$error("depth_byte: expected %0d actual %0d", e.depth_byte, db);
				errors++;
			end
			if (ra !== e.read_address) begin
				$error("read_address: expected %0d actual %0d", e.read_address, ra);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [31:0] cfg_data;

	psdb_req_if req_if();
	psdb_rsp_if rsp_if();

	point_splat_depth_buffer_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_if),
		.rsp      (rsp_if),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	depth_image_scoreboard sb = new();
	int burst_left;
	int idle_cycles;
	int cycle_count;
	int items_sent;
	int hot_u[$];
	int hot_v[$];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result side stall pattern
	always @(negedge clk) begin
		cycle_count <= cycle_count + 1;
		case ((cycle_count / 400) % 4)
			0: rsp_if.ready <= 1'b1;
			1: rsp_if.ready <= $urandom_range(0, 1);
			2: rsp_if.ready <= (cycle_count % 13) < 4;
			default: rsp_if.ready <= $urandom_range(0, 9) != 0;
		endcase
	end

	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready)
			sb.check_result(rsp_if.depth_value, rsp_if.depth_byte, rsp_if.read_address);
	end

	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("point_splat_depth_buffer_top test failed");
			$finish;
		end
	end

	task automatic send_item(logic [1:0] op, logic signed [31:0] x, logic signed [31:0] y,
			logic signed [31:0] z, logic [18:0] addr);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				req_if.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		req_if.valid = 1'b1;
		req_if.opcode = op;
		req_if.cam_x = x;
		req_if.cam_y = y;
		req_if.cam_z = z;
		req_if.pixel_address = addr;
		do @(posedge clk); while (!req_if.ready);
		sb.note_item(op, x, y, z, addr);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// a read at the end makes sure any clear sweep or splat has finished
	task automatic drain();
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'($urandom_range(0, PIXELS - 1)));
		req_if.valid = 1'b0;
		burst_left = 0;
		while (sb.pending_reads.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	// point aimed at pixel (u, v) at depth z with the current intrinsics
	task automatic splat_at(int u, int v, logic signed [31:0] z);
		longint x, y;
		x = ((longint'(u) * 256 - longint'(sb.cx)) * z) / longint'(sb.fx);
		y = ((longint'(v) * 256 - longint'(sb.cy)) * z) / longint'(sb.fy);
		x += $signed($urandom_range(0, 64)) - 32;
		y += $signed($urandom_range(0, 64)) - 32;
		hot_u = {hot_u, u};
		hot_v = {hot_v, v};
		if (hot_u.size() > 16) begin
			void'(hot_u.pop_front());
			void'(hot_v.pop_front());
		end
		send_item(psdb_pkg::OP_SPLAT, 32'(x), 32'(y), z, 19'($urandom_range(0, 524287)));
	endtask

	task automatic random_traffic(int count);
		int k, sel, h;
		longint z, span;
		for (k = 0; k < count; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < 50) begin
				span = longint'(sb.far_z) - longint'(sb.near_z);
				if (span <= 0)
					span = 1;
				z = longint'(sb.near_z) + 1 + ($urandom() % span);
				if (z > 32'h7FFF_FFFF || sb.far_z <= sb.near_z)
					z = $urandom_range(1, 1000000);
				splat_at($urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1), 32'(z));
			end else if (sel < 60) begin
				send_item(psdb_pkg::OP_SPLAT, $urandom(), $urandom(), $urandom(),
					19'($urandom()));
			end else if (sel < 92 && hot_u.size() > 0) begin
				h = $urandom_range(0, hot_u.size() - 1);
				send_item(psdb_pkg::OP_READ, $urandom(), $urandom(), $urandom(),
					19'((hot_v[h] + $signed($urandom_range(0, 10)) - 5 + IMG_H) % IMG_H * IMG_W +
					(hot_u[h] + $signed($urandom_range(0, 10)) - 5 + IMG_W) % IMG_W));
			end else if (sel < 97) begin
				send_item(psdb_pkg::OP_READ, $urandom(), $urandom(), $urandom(),
					19'($urandom()));
			end else begin
				send_item(OP_IGNORED, $urandom(), $urandom(), $urandom(), 19'($urandom()));
				k--;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = psdb_pkg::CFG_FOCAL_X;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.opcode = psdb_pkg::OP_CLEAR;
		req_if.cam_x = '0;
		req_if.cam_y = '0;
		req_if.cam_z = '0;
		req_if.pixel_address = '0;
		burst_left = 0;
		items_sent = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		drain();

		// directed: defaults
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'd0);
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'(PIXELS - 1));
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'(PIXELS));
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'h7FFFF);
		splat_at(320, 240, 32'd655360);
		splat_at(320, 240, 32'd3277);
		splat_at(321, 240, 32'd3278);
		splat_at(0, 0, 32'd65536);
		splat_at(IMG_W - 1, IMG_H - 1, 32'd131072);
		send_item(psdb_pkg::OP_SPLAT, 32'h8000_0000, 32'h7FFF_FFFF, 32'd65536, 19'd0);
		send_item(psdb_pkg::OP_SPLAT, 0, 0, 32'h8000_0000, 19'd0);
		send_item(psdb_pkg::OP_SPLAT, 0, 0, 32'h7FFF_FFFF, 19'd0);
		send_item(psdb_pkg::OP_SPLAT, 32'd10, 32'd10, 32'd0, 19'd0);
		send_item(OP_IGNORED, $urandom(), $urandom(), $urandom(), 19'h7FFFF);
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'(240 * IMG_W + 320));
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'(241 * IMG_W + 322));
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'd1);
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'(PIXELS - 2));
		send_item(psdb_pkg::OP_CLEAR, 0, 0, 0, 19'd0);
		send_item(psdb_pkg::OP_READ, 0, 0, 0, 19'(240 * IMG_W + 320));
		drain();
		random_traffic(200);
		drain();

		// no frustum, zero radius, smallest and largest focal lengths, extreme centers
		write_reg(psdb_pkg::CFG_FRUSTUM_EN, 32'd0);
		write_reg(psdb_pkg::CFG_SPLAT_RAD, 32'd0);
		write_reg(psdb_pkg::CFG_FOCAL_X, 32'd1);
		write_reg(psdb_pkg::CFG_FOCAL_Y, 32'hFF_FFFF);
		write_reg(psdb_pkg::CFG_CENTER_X, 32'd0);
		write_reg(psdb_pkg::CFG_CENTER_Y, 32'hFF_FFFF);
		random_traffic(150);
		drain();

		// widest splat, saturated radius, depth window extremes
		write_reg(psdb_pkg::CFG_FOCAL_X, 32'd64000);
		write_reg(psdb_pkg::CFG_FOCAL_Y, 32'd70000);
		write_reg(psdb_pkg::CFG_CENTER_X, 32'd163584);
		write_reg(psdb_pkg::CFG_CENTER_Y, 32'd0);
		write_reg(psdb_pkg::CFG_FRUSTUM_EN, 32'd1);
		write_reg(psdb_pkg::CFG_SPLAT_RAD, 32'd4);
		write_reg(psdb_pkg::CFG_NEAR_DEPTH, 32'd0);
		write_reg(psdb_pkg::CFG_FAR_DEPTH, 32'hFFFF_FFFF);
		random_traffic(200);
		drain();
		write_reg(psdb_pkg::CFG_SPLAT_RAD, 32'd7);
		random_traffic(120);
		drain();
		write_reg(psdb_pkg::CFG_SPLAT_RAD, 32'd5);
		write_reg(psdb_pkg::CFG_FAR_DEPTH, 32'd1);
		random_traffic(60);
		drain();

		// zero far depth: nothing splats, stored depths read as full scale
		write_reg(psdb_pkg::CFG_FAR_DEPTH, 32'd0);
		write_reg(psdb_pkg::CFG_NEAR_DEPTH, 32'hFFFF_FFFF);
		random_traffic(80);
		drain();

		write_reg(psdb_pkg::CFG_NEAR_DEPTH, 32'd1000);
		write_reg(psdb_pkg::CFG_FAR_DEPTH, 32'd2000000);
		write_reg(psdb_pkg::CFG_SPLAT_RAD, 32'd2);
		write_reg(psdb_pkg::CFG_CENTER_X, 32'd81920);
		write_reg(psdb_pkg::CFG_CENTER_Y, 32'd61440);
		send_item(psdb_pkg::OP_CLEAR, 0, 0, 0, 19'd0);
		random_traffic(400);
		drain();

		$display("covered %0d items, %0d points written, %0d pixel reads checked",
			items_sent, sb.points_written, sb.reads_checked);
		$display("settings: defaults, frustum off, radius 0 to 7, far depth 0 to max, two clears");
		if (sb.errors == 0)
			$display("point_splat_depth_buffer_top test passed");
		else
			$display("point_splat_depth_buffer_top test failed");
		$finish;
	end

endmodule

@@ sim.f @@
design/psdb_pkg.sv
design/psdb_req_if.sv
design/psdb_rsp_if.sv
design/psdb_div.sv
design/point_splat_depth_buffer_top.sv
tb/sv/point_splat_depth_buffer_top_tb.sv
